FILE: rtl/sapds_pkg.sv
// Types and constants shared by the scan and poll deadline scheduler.
package sapds_pkg;

  localparam int IN_TIME_W = 40;
  localparam int REG_W     = 27;
  localparam int BACKOFF_W = 17;

  // Retry backoff after a failed scan, indexed by the failure count.
  localparam logic [BACKOFF_W-1:0] BACKOFF_MS [4] = '{
    17'd15000, 17'd30000, 17'd60000, 17'd120000
  };

  localparam logic [1:0] FAIL_MAX = 2'd3;

  typedef enum logic [2:0] {
    ACT_EVAL       = 3'd0,
    ACT_INIT       = 3'd1,
    ACT_WAKE       = 3'd2,
    ACT_LOST       = 3'd3,
    ACT_FAILED     = 3'd4,
    ACT_IDENTITY   = 3'd5,
    ACT_NEW_PATH   = 3'd6,
    ACT_QUOTA_DONE = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    CFG_RECOVERY_INTERVAL = 2'd0,
    CFG_SCAN_WINDOW       = 2'd1,
    CFG_QUOTA_INTERVAL    = 2'd2,
    CFG_QUOTA_SPACING     = 2'd3
  } cfg_reg_t;

  localparam logic [REG_W-1:0] RST_RECOVERY_INTERVAL = 27'd60000;
  localparam logic [REG_W-1:0] RST_SCAN_WINDOW       = 27'd10000;
  localparam logic [REG_W-1:0] RST_QUOTA_INTERVAL    = 27'd300000;
  localparam logic [REG_W-1:0] RST_QUOTA_SPACING     = 27'd30000;

  typedef struct packed {
    action_t              action;
    logic [IN_TIME_W-1:0] now_ms;
    logic                 radio_on;
    logic                 wired_ready;
    logic                 link_busy;
    logic                 quota_path_ready;
  } in_item_t;

  typedef struct packed {
    logic                 do_recover;
    logic                 do_stop_scan;
    logic                 do_start_scan;
    logic                 do_read_quota;
    logic [IN_TIME_W-1:0] next_deadline_ms;
  } out_item_t;

  typedef struct packed {
    logic             en;
    cfg_reg_t         index;
    logic [REG_W-1:0] data;
  } cfg_wr_t;

endpackage

FILE: rtl/sapds_core.sv
// Scheduler state, configuration registers and the per-event update logic.
module sapds_core import sapds_pkg::*; #(
  parameter int TIME_BITS = 40
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_wr_t   cfg,
  input  logic      step,
  input  in_item_t  item,
  output out_item_t res
);

  localparam int W = TIME_BITS;

  logic [REG_W-1:0] recovery_interval_r, scan_window_r, quota_interval_r, quota_spacing_r;

  logic [W-1:0] scan_due_r, scan_ends_r, recovery_due_r, quota_due_r, quota_earliest_r;
  logic [W-1:0] scan_due_nxt, scan_ends_nxt, recovery_due_nxt, quota_due_nxt;
  logic [W-1:0] quota_earliest_nxt;
  logic [1:0]   fail_count_r, fail_count_nxt;
  logic         scan_active_r, scan_active_nxt, quota_busy_r, quota_busy_nxt;

  logic [63:0]  now_ext, nd_ext;
  logic [W-1:0] now_v, backoff_at, new_path_due, next_v;
  logic [1:0]   fail_inc;
  logic         quiet, rec, stop, start, readq;

  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [REG_W-1:0] b);
    logic [W:0] s;
    s = {1'b0, a} + (W+1)'(b);
    return s[W] ? {W{1'b1}} : s[W-1:0];
  endfunction

  function automatic logic [W-1:0] tmin(input logic [W-1:0] a, input logic [W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  always_comb begin
    now_ext      = 64'(item.now_ms);
    now_v        = now_ext[W-1:0];
    quiet        = !item.radio_on || item.wired_ready || item.link_busy;
    backoff_at   = sat_add(now_v, REG_W'(BACKOFF_MS[fail_count_r]));
    fail_inc     = (fail_count_r == FAIL_MAX) ? FAIL_MAX : fail_count_r + 2'd1;
    new_path_due = quota_busy_r ? quota_due_r
                 : tmin(quota_due_r, (now_v > quota_earliest_r) ? now_v : quota_earliest_r);

    scan_due_nxt       = scan_due_r;
    scan_ends_nxt      = scan_ends_r;
    recovery_due_nxt   = recovery_due_r;
    quota_due_nxt      = quota_due_r;
    quota_earliest_nxt = quota_earliest_r;
    fail_count_nxt     = fail_count_r;
    scan_active_nxt    = scan_active_r;
    quota_busy_nxt     = quota_busy_r;
    rec   = 1'b0;
    stop  = 1'b0;
    start = 1'b0;
    readq = 1'b0;

    case (item.action)
      ACT_EVAL: begin
        if (now_v >= recovery_due_r) begin
          rec              = 1'b1;
          recovery_due_nxt = sat_add(now_v, recovery_interval_r);
        end
        if (quiet) begin
          stop            = scan_active_r;
          scan_active_nxt = 1'b0;
        end else if (scan_active_r && now_v >= scan_ends_r) begin
          // window ran out: count as a failed scan
          stop            = 1'b1;
          scan_active_nxt = 1'b0;
          fail_count_nxt  = fail_inc;
          scan_due_nxt    = backoff_at;
        end else if (!scan_active_r && now_v >= scan_due_r) begin
          start           = 1'b1;
          scan_active_nxt = 1'b1;
          scan_ends_nxt   = sat_add(now_v, scan_window_r);
        end
        if (item.quota_path_ready && !quota_busy_r && now_v >= quota_due_r) begin
          readq              = 1'b1;
          quota_busy_nxt     = 1'b1;
          quota_earliest_nxt = sat_add(now_v, quota_spacing_r);
          quota_due_nxt      = sat_add(now_v, quota_interval_r);
        end
      end
      ACT_INIT: begin
        scan_due_nxt       = now_v;
        scan_ends_nxt      = '0;
        recovery_due_nxt   = sat_add(now_v, recovery_interval_r);
        quota_due_nxt      = now_v;
        quota_earliest_nxt = now_v;
        fail_count_nxt     = '0;
        scan_active_nxt    = 1'b0;
        quota_busy_nxt     = 1'b0;
      end
      ACT_WAKE: begin
        scan_due_nxt     = now_v;
        fail_count_nxt   = '0;
        recovery_due_nxt = now_v;
        quota_due_nxt    = new_path_due;
      end
      ACT_LOST: begin
        scan_due_nxt   = now_v;
        fail_count_nxt = '0;
      end
      ACT_FAILED: begin
        scan_active_nxt = 1'b0;
        fail_count_nxt  = fail_inc;
        scan_due_nxt    = backoff_at;
      end
      ACT_IDENTITY: recovery_due_nxt = now_v;
      ACT_NEW_PATH: quota_due_nxt = new_path_due;
      ACT_QUOTA_DONE: quota_busy_nxt = 1'b0;
      default: quota_busy_nxt = quota_busy_r;
    endcase

    // deadline is taken from the state after this event
    next_v = recovery_due_nxt;
    if (!quiet) next_v = tmin(next_v, scan_active_nxt ? scan_ends_nxt : scan_due_nxt);
    if (item.quota_path_ready && !quota_busy_nxt) next_v = tmin(next_v, quota_due_nxt);
    nd_ext = 64'(next_v);

    res.do_recover       = rec;
    res.do_stop_scan     = stop;
    res.do_start_scan    = start;
    res.do_read_quota    = readq;
    res.next_deadline_ms = nd_ext[IN_TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recovery_interval_r <= RST_RECOVERY_INTERVAL;
      scan_window_r       <= RST_SCAN_WINDOW;
      quota_interval_r    <= RST_QUOTA_INTERVAL;
      quota_spacing_r     <= RST_QUOTA_SPACING;
      scan_due_r          <= '0;
      scan_ends_r         <= '0;
      recovery_due_r      <= '0;
      quota_due_r         <= '0;
      quota_earliest_r    <= '0;
      fail_count_r        <= '0;
      scan_active_r       <= 1'b0;
      quota_busy_r        <= 1'b0;
    end else begin
      if (cfg.en) begin
        case (cfg.index)
          CFG_RECOVERY_INTERVAL: recovery_interval_r <= cfg.data;
          CFG_SCAN_WINDOW:       scan_window_r       <= cfg.data;
          CFG_QUOTA_INTERVAL:    quota_interval_r    <= cfg.data;
          CFG_QUOTA_SPACING:     quota_spacing_r     <= cfg.data;
          default:               recovery_interval_r <= recovery_interval_r;
        endcase
      end
      if (step) begin
        scan_due_r       <= scan_due_nxt;
        scan_ends_r      <= scan_ends_nxt;
        recovery_due_r   <= recovery_due_nxt;
        quota_due_r      <= quota_due_nxt;
        quota_earliest_r <= quota_earliest_nxt;
        fail_count_r     <= fail_count_nxt;
        scan_active_r    <= scan_active_nxt;
        quota_busy_r     <= quota_busy_nxt;
      end
    end
  end

  a_start_stop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    step |-> !(res.do_start_scan && res.do_stop_scan))
    else $error("scan start and stop in one result");

  a_start_sets_active: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.do_start_scan) |=> scan_active_r)
    else $error("scan start did not mark scan active");

  a_read_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.do_read_quota) |-> (!quota_busy_r ##1 quota_busy_r))
    else $error("quota read issued while one is in flight");

endmodule

FILE: rtl/scan_and_poll_deadline_scheduler.sv
// Top level of the scan and poll deadline scheduler: input and result registers.
//
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_ready    in_data   (in_item_t)
//  out_     output     out_valid / out_ready  out_data  (out_item_t)
//  cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One event per cycle while out_ready is high; each event goes from input register
// to result register, with all state updated in the single pass between them.
// Reset (rst_n low, synchronous) clears all timers and flags and loads the
// default register values; no clearing pass follows.
// With out_ready low the result holds, the input register fills, then in_ready
// drops. Configuration writes are taken in every cycle.
module scan_and_poll_deadline_scheduler import sapds_pkg::*; #(
  parameter int TIME_BITS = 40
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  cfg_reg_t         cfg_index,
  input  logic [REG_W-1:0] cfg_data
);

  logic      hold_valid_r;
  in_item_t  hold_r;
  logic      out_valid_r;
  out_item_t out_r;
  logic      advance;
  out_item_t res;
  cfg_wr_t   cfg;

  assign cfg_ready = 1'b1;
  assign cfg.en    = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // move the held event into the result register when that slot is free
  assign advance   = hold_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !hold_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  sapds_core #(.TIME_BITS(TIME_BITS)) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .step  (advance),
    .item  (hold_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_ready) hold_valid_r <= in_valid;
      if (advance) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) hold_r <= in_data;
    if (advance) out_r <= res;
  end

endmodule
